// ----- rtl/bdhr_pkg.sv -----
// ----------------------------------------------------------------------------
// bdhr_pkg
// Types, codes and reset values shared by the button debounce and repeat block.
// ----------------------------------------------------------------------------
package bdhr_pkg;

  localparam int unsigned TIME_BITS_DEFAULT = 12;
  localparam int unsigned CFG_W             = 12;
  localparam int unsigned CFG_IDX_W         = 3;
  localparam int unsigned REP_W             = 8;

  localparam logic [REP_W-1:0] SLOW_AFTER = REP_W'(3);
  localparam logic [REP_W-1:0] FAST_AFTER = REP_W'(5);
  localparam logic [REP_W-1:0] REP_MAX    = '1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(50);
  localparam logic [CFG_W-1:0] HOLD_RST     = CFG_W'(800);
  localparam logic [CFG_W-1:0] INITIAL_RST  = CFG_W'(300);
  localparam logic [CFG_W-1:0] SLOW_RST     = CFG_W'(150);
  localparam logic [CFG_W-1:0] FAST_RST     = CFG_W'(50);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 3'd0,
    REG_HOLD     = 3'd1,
    REG_INITIAL  = 3'd2,
    REG_SLOW     = 3'd3,
    REG_FAST     = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_NONE        = 2'd0,
    OP_TAKE_PRESS  = 2'd1,
    OP_TAKE_REPEAT = 2'd2,
    OP_CLEAR       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    SEL_INITIAL = 2'd0,
    SEL_SLOW    = 2'd1,
    SEL_FAST    = 2'd2
  } interval_sel_e;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CFG_W-1:0] initial_interval_ms;
    logic [CFG_W-1:0] slow_interval_ms;
    logic [CFG_W-1:0] fast_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic       pin_level;
    logic [1:0] op;
  } in_item_t;

  typedef struct packed {
    logic             level_stable;
    logic             press_pending;
    logic             holding;
    logic             taken;
    logic [REP_W-1:0] repeat_count;
  } out_item_t;

endpackage

// ----- rtl/bdhr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bdhr_cfg_regs
// Timing register file, written one register per configuration transfer.
// ----------------------------------------------------------------------------
module bdhr_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            wr_en_i,
  input  logic [bdhr_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [bdhr_pkg::CFG_W-1:0]      wr_data_i,
  output bdhr_pkg::cfg_t                  cfg_o
);

  bdhr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (bdhr_pkg::cfg_reg_e'(wr_index_i))
        bdhr_pkg::REG_DEBOUNCE: cfg_d.debounce_ms         = wr_data_i;
        bdhr_pkg::REG_HOLD:     cfg_d.hold_ms             = wr_data_i;
        bdhr_pkg::REG_INITIAL:  cfg_d.initial_interval_ms = wr_data_i;
        bdhr_pkg::REG_SLOW:     cfg_d.slow_interval_ms    = wr_data_i;
        bdhr_pkg::REG_FAST:     cfg_d.fast_interval_ms    = wr_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms         <= bdhr_pkg::DEBOUNCE_RST;
      cfg_q.hold_ms             <= bdhr_pkg::HOLD_RST;
      cfg_q.initial_interval_ms <= bdhr_pkg::INITIAL_RST;
      cfg_q.slow_interval_ms    <= bdhr_pkg::SLOW_RST;
      cfg_q.fast_interval_ms    <= bdhr_pkg::FAST_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/bdhr_tick.sv -----
// ----------------------------------------------------------------------------
// bdhr_tick
// Per-tick state update: debounce, press latch, hold entry, auto-repeat, op.
// ----------------------------------------------------------------------------
module bdhr_tick #(
  parameter int unsigned TIME_BITS = bdhr_pkg::TIME_BITS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  bdhr_pkg::in_item_t  item_i,
  input  bdhr_pkg::cfg_t      cfg_i,
  output bdhr_pkg::out_item_t result_o
);

  localparam int unsigned CMP_W =
    (TIME_BITS > bdhr_pkg::CFG_W) ? TIME_BITS : bdhr_pkg::CFG_W;

  logic                          last_sample_q, last_sample_d;
  logic                          stable_q, stable_d;
  logic                          pending_q, pending_d;
  logic                          hold_q, hold_d;
  logic [TIME_BITS-1:0]          since_change_q, since_change_d;
  logic [TIME_BITS-1:0]          since_press_q, since_press_d;
  logic [TIME_BITS-1:0]          since_action_q, since_action_d;
  logic [bdhr_pkg::REP_W-1:0]    repeats_q, repeats_d;
  bdhr_pkg::interval_sel_e       sel_q, sel_d;
  logic [bdhr_pkg::CFG_W-1:0]    interval;
  logic                          taken;

  function automatic logic [TIME_BITS-1:0] sat_inc(input logic [TIME_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  always_comb begin
    since_change_d = sat_inc(since_change_q);
    since_press_d  = sat_inc(since_press_q);
    since_action_d = sat_inc(since_action_q);
    stable_d       = stable_q;
    pending_d      = pending_q;
    hold_d         = hold_q;
    repeats_d      = repeats_q;
    sel_d          = sel_q;
    taken          = 1'b0;

    if (item_i.pin_level != last_sample_q) begin
      since_change_d = '0;
    end

    if (CMP_W'(since_change_d) >= CMP_W'(cfg_i.debounce_ms) &&
        item_i.pin_level != stable_q) begin
      stable_d = item_i.pin_level;
      hold_d   = 1'b0;
      if (!item_i.pin_level) begin
        since_press_d  = '0;
        since_action_d = '0;
        pending_d      = 1'b1;
        repeats_d      = '0;
        sel_d          = bdhr_pkg::SEL_INITIAL;
      end
    end

    if (!stable_d && !hold_d && CMP_W'(since_press_d) >= CMP_W'(cfg_i.hold_ms)) begin
      hold_d         = 1'b1;
      since_action_d = '0;
    end

    case (sel_d)
      bdhr_pkg::SEL_INITIAL: interval = cfg_i.initial_interval_ms;
      bdhr_pkg::SEL_SLOW:    interval = cfg_i.slow_interval_ms;
      default:               interval = cfg_i.fast_interval_ms;
    endcase

    if (!stable_d && hold_d && CMP_W'(since_action_d) >= CMP_W'(interval)) begin
      since_action_d = '0;
      if (repeats_d != bdhr_pkg::REP_MAX) begin
        repeats_d = repeats_d + 1'b1;
      end
      if (repeats_d >= bdhr_pkg::FAST_AFTER) begin
        sel_d = bdhr_pkg::SEL_FAST;
      end else if (repeats_d >= bdhr_pkg::SLOW_AFTER) begin
        sel_d = bdhr_pkg::SEL_SLOW;
      end
      pending_d = 1'b1;
    end

    last_sample_d = item_i.pin_level;

    case (bdhr_pkg::op_e'(item_i.op))
      bdhr_pkg::OP_TAKE_PRESS: begin
        if (pending_d) begin
          pending_d = 1'b0;
          taken     = 1'b1;
        end
      end
      bdhr_pkg::OP_TAKE_REPEAT: begin
        if (hold_d && pending_d) begin
          pending_d = 1'b0;
          taken     = 1'b1;
        end
      end
      bdhr_pkg::OP_CLEAR: begin
        repeats_d = '0;
        sel_d     = bdhr_pkg::SEL_INITIAL;
        hold_d    = 1'b0;
        pending_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sample_q  <= 1'b1;
      stable_q       <= 1'b1;
      pending_q      <= 1'b0;
      hold_q         <= 1'b0;
      since_change_q <= '0;
      since_press_q  <= '0;
      since_action_q <= '0;
      repeats_q      <= '0;
      sel_q          <= bdhr_pkg::SEL_INITIAL;
    end else if (step_i) begin
      last_sample_q  <= last_sample_d;
      stable_q       <= stable_d;
      pending_q      <= pending_d;
      hold_q         <= hold_d;
      since_change_q <= since_change_d;
      since_press_q  <= since_press_d;
      since_action_q <= since_action_d;
      repeats_q      <= repeats_d;
      sel_q          <= sel_d;
    end
  end

  assign result_o.level_stable  = stable_d;
  assign result_o.press_pending = pending_d;
  assign result_o.holding       = hold_d;
  assign result_o.taken         = taken;
  assign result_o.repeat_count  = repeats_d;

endmodule

// ----- rtl/button_debounce_hold_repeat.sv -----
// ----------------------------------------------------------------------------
// button_debounce_hold_repeat
// Debounced active-low button with hold detection and accelerating auto-repeat.
//
//   channel  direction  signals                                    payload
//   in       input      in_valid_i / in_ready_o                    in_data_i
//   out      output     out_valid_o / out_ready_i                  out_data_o
//   cfg      input      cfg_valid_i / cfg_ready_o                  cfg_index_i, cfg_data_i
//
// One tick per cycle while the output register is drained: each input transfer is processed in the
// cycle it is taken and its result sits in the output register on the next cycle.
// The input is ready whenever the output register is empty or being drained.
// Reset restores the register defaults and the released button state.
// Configuration transfers are always taken.
// ----------------------------------------------------------------------------
module button_debounce_hold_repeat #(
  parameter int unsigned TIME_BITS = bdhr_pkg::TIME_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bdhr_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bdhr_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bdhr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bdhr_pkg::CFG_W-1:0]      cfg_data_i
);

  bdhr_pkg::cfg_t      cfg;
  bdhr_pkg::out_item_t result;
  bdhr_pkg::out_item_t out_data_q;
  logic                out_valid_q, out_valid_d;
  logic                in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  bdhr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  bdhr_tick #(
    .TIME_BITS (TIME_BITS)
  ) u_tick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_xfer),
    .item_i   (in_data_i),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
